[hdl/eed_pkg.sv]
// ----------------------------------------------------------------------------
// eed_pkg
// Shared constants, register codes and types of the energy end-point detector.
// ----------------------------------------------------------------------------
package eed_pkg;

    localparam int FRAME_SAMPLES = 160;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int HANG_W   = 10;
    localparam int FRAMES_W = 12;
    localparam int ENERGY_W = 16;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;

    localparam int SUM_W  = $clog2(FRAME_SAMPLES * 32768 + 1);
    localparam int CNT_W  = $clog2(FRAME_SAMPLES + 1);
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [IDX_W-1:0] REG_SILENCE_LEVEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_HANG_LIMIT    = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_CAP     = 2'd2;

    localparam logic [LEVEL_W-1:0]  SILENCE_LEVEL_RST = 16'd60;
    localparam logic [HANG_W-1:0]   HANG_LIMIT_RST    = 10'd50;
    localparam logic [FRAMES_W-1:0] FRAME_CAP_RST     = 12'd600;

    localparam logic [HANG_W-1:0]   SILENT_MAX = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;

    typedef struct packed {
        logic clear;
        logic accum;
        logic load_div;
        logic div_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic done;
    } t_status;

    typedef struct packed {
        logic [ENERGY_W-1:0] frame_energy;
        logic                frame_silent;
        logic [HANG_W-1:0]   silent_run;
        logic [FRAMES_W-1:0] frame_total;
        logic [ENERGY_W-1:0] energy_min;
        logic [ENERGY_W-1:0] energy_max;
        logic                done_res;
    } t_result;

endpackage

[hdl/eed_smp_if.sv]
// ----------------------------------------------------------------------------
// eed_smp_if
// Input stream of commands and audio samples.
// ----------------------------------------------------------------------------
interface eed_smp_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [eed_pkg::SAMPLE_W-1:0] sample;
    logic                                frame_end;

    modport source (output valid, output cmd, output sample, output frame_end,
                    input ready);
    modport sink   (input valid, input cmd, input sample, input frame_end,
                    output ready);
endinterface

[hdl/eed_res_if.sv]
// ----------------------------------------------------------------------------
// eed_res_if
// Output stream of per-frame results.
// ----------------------------------------------------------------------------
interface eed_res_if;
    logic                         valid;
    logic                         ready;
    logic [eed_pkg::ENERGY_W-1:0] frame_energy;
    logic                         frame_silent;
    logic [eed_pkg::HANG_W-1:0]   silent_run;
    logic [eed_pkg::FRAMES_W-1:0] frame_total;
    logic [eed_pkg::ENERGY_W-1:0] energy_min;
    logic [eed_pkg::ENERGY_W-1:0] energy_max;
    logic                         done_res;

    modport source (output valid, output frame_energy, output frame_silent,
                    output silent_run, output frame_total, output energy_min,
                    output energy_max, output done_res, input ready);
    modport sink   (input valid, input frame_energy, input frame_silent,
                    input silent_run, input frame_total, input energy_min,
                    input energy_max, input done_res, output ready);
endinterface

[hdl/eed_cfg_if.sv]
// ----------------------------------------------------------------------------
// eed_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface eed_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [eed_pkg::IDX_W-1:0] index;
    logic [eed_pkg::CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/eed_datapath.sv]
// ----------------------------------------------------------------------------
// eed_datapath
// Configuration registers, magnitude accumulator, serial divider, frame
// statistics and result register.
// ----------------------------------------------------------------------------
module eed_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [eed_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [eed_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic signed [eed_pkg::SAMPLE_W-1:0] i_sample,
    input  eed_pkg::t_cmd                       i_cmd,
    output eed_pkg::t_status                    o_status,
    output eed_pkg::t_result                    o_result
);

    logic [eed_pkg::LEVEL_W-1:0]  r_level;
    logic [eed_pkg::HANG_W-1:0]   r_hang;
    logic [eed_pkg::FRAMES_W-1:0] r_maxf;

    logic [eed_pkg::SUM_W-1:0]    r_sum;
    logic [eed_pkg::CNT_W-1:0]    r_cnt;
    logic [eed_pkg::HANG_W-1:0]   r_silent;
    logic [eed_pkg::FRAMES_W-1:0] r_frames;
    logic [eed_pkg::ENERGY_W-1:0] r_min;
    logic [eed_pkg::ENERGY_W-1:0] r_max;

    logic [eed_pkg::SUM_W-1:0]    r_quo;
    logic [eed_pkg::CNT_W-1:0]    r_rem;
    logic [eed_pkg::CNT_W-1:0]    r_dvs;
    logic                         r_dvz;
    logic [eed_pkg::STEP_W-1:0]   r_step;

    eed_pkg::t_result             r_res;

    logic [eed_pkg::SAMPLE_W-1:0] w_mag;
    logic [eed_pkg::CNT_W:0]      w_trial;
    logic [eed_pkg::CNT_W:0]      w_diff;
    logic                         w_ge;
    logic [eed_pkg::ENERGY_W-1:0] w_energy;
    logic                         w_silent;
    logic [eed_pkg::HANG_W-1:0]   n_silent;
    logic [eed_pkg::FRAMES_W-1:0] n_frames;
    logic [eed_pkg::ENERGY_W-1:0] n_min;
    logic [eed_pkg::ENERGY_W-1:0] n_max;
    logic                         w_done;

    assign w_mag   = i_sample[eed_pkg::SAMPLE_W-1] ? eed_pkg::SAMPLE_W'(-i_sample)
                                                   : eed_pkg::SAMPLE_W'(i_sample);
    assign w_trial = {r_rem, r_quo[eed_pkg::SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    assign w_energy = r_dvz ? '0 : r_quo[eed_pkg::ENERGY_W-1:0];
    assign w_silent = w_energy < r_level;
    assign n_silent = !w_silent ? '0 :
                      (r_silent == eed_pkg::SILENT_MAX) ? r_silent : r_silent + 1'b1;
    assign n_frames = (r_frames == eed_pkg::FRAMES_MAX) ? r_frames : r_frames + 1'b1;
    assign n_min    = (w_energy < r_min) ? w_energy : r_min;
    assign n_max    = (w_energy > r_max) ? w_energy : r_max;
    assign w_done   = (n_silent >= r_hang) || (n_frames >= r_maxf);

    assign o_status.div_last = r_step == '0;
    assign o_status.done     = w_done;
    assign o_result          = r_res;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= eed_pkg::SILENCE_LEVEL_RST;
            r_hang  <= eed_pkg::HANG_LIMIT_RST;
            r_maxf  <= eed_pkg::FRAME_CAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                eed_pkg::REG_SILENCE_LEVEL: r_level <= i_cfg_data[eed_pkg::LEVEL_W-1:0];
                eed_pkg::REG_HANG_LIMIT:    r_hang  <= i_cfg_data[eed_pkg::HANG_W-1:0];
                eed_pkg::REG_FRAME_CAP:     r_maxf  <= i_cfg_data[eed_pkg::FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    // accumulator and utterance statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum    <= '0;
            r_cnt    <= '0;
            r_silent <= '0;
            r_frames <= '0;
            r_min    <= '1;
            r_max    <= '0;
        end else begin
            if (i_cmd.accum && (r_cnt < eed_pkg::CNT_W'(eed_pkg::FRAME_SAMPLES))) begin
                r_sum <= r_sum + eed_pkg::SUM_W'(w_mag);
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.load_div) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.update) begin
                r_silent <= n_silent;
                r_frames <= n_frames;
                r_min    <= n_min;
                r_max    <= n_max;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_dvs  <= r_cnt;
            r_dvz  <= r_cnt == '0;
            r_step <= eed_pkg::STEP_W'(eed_pkg::SUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[eed_pkg::SUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[eed_pkg::CNT_W-1:0] : w_trial[eed_pkg::CNT_W-1:0];
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res.frame_energy <= w_energy;
            r_res.frame_silent <= w_silent;
            r_res.silent_run   <= n_silent;
            r_res.frame_total  <= n_frames;
            r_res.energy_min   <= n_min;
            r_res.energy_max   <= n_max;
            r_res.done_res     <= w_done;
        end
    end

endmodule

[hdl/eed_ctrl.sv]
// ----------------------------------------------------------------------------
// eed_ctrl
// Sequencer: accepts transactions, runs the divider at frame end and
// hands results to the output register.
// ----------------------------------------------------------------------------
module eed_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    input  logic             i_in_frame_end,
    input  logic             i_out_ready,
    input  eed_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output eed_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_LOAD,
        S_DIV,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_active;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = r_state == S_RUN;
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = w_accept && i_in_cmd;
        o_cmd.accum    = w_accept && !i_in_cmd && r_active;
        o_cmd.load_div = r_state == S_LOAD;
        o_cmd.div_step = r_state == S_DIV;
        o_cmd.update   = (r_state == S_UPD) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (w_accept && i_in_cmd) begin
                        r_active <= 1'b1;
                    end else if (w_accept && r_active && i_in_frame_end) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_out_free) begin
                        r_state <= S_RUN;
                        if (i_status.done) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    a_load_then_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_state == S_DIV)
        else $error("divider load not followed by divide");

    a_update_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> r_out_valid)
        else $error("result not presented after update");

    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> r_active && r_state == S_RUN)
        else $error("start did not activate");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update && i_status.done |=> !r_active)
        else $error("utterance still active after done");

endmodule

[hdl/energy_endpoint_detector.sv]
// ----------------------------------------------------------------------------
// energy_endpoint_detector
// Utterance end-point detector: per-frame mean absolute energy, silence
// hangover and frame cap.
// ----------------------------------------------------------------------------
// A sample transaction is taken while the sequencer is in its run state. The
// transaction that carries the frame end mark is accumulated, then the
// divider is loaded, the one-bit-per-cycle restoring divider runs and the
// statistics are updated once the previous result has left the output
// register; no new transaction is taken until then. A start command
// produces no result; the block drops samples until a start, and again after
// the result that reports done. Configuration writes are taken every cycle.
module energy_endpoint_detector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eed_smp_if.sink   i_smp,
    eed_res_if.source o_res,
    eed_cfg_if.sink   i_cfg
);

    eed_pkg::t_cmd    w_cmd;
    eed_pkg::t_status w_status;
    eed_pkg::t_result w_result;
    logic             w_in_ready;
    logic             w_out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

    assign o_res.frame_energy = w_result.frame_energy;
    assign o_res.frame_silent = w_result.frame_silent;
    assign o_res.silent_run   = w_result.silent_run;
    assign o_res.frame_total  = w_result.frame_total;
    assign o_res.energy_min   = w_result.energy_min;
    assign o_res.energy_max   = w_result.energy_max;
    assign o_res.done_res     = w_result.done_res;

    eed_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_smp.valid),
        .i_in_cmd       (i_smp.cmd),
        .i_in_frame_end (i_smp.frame_end),
        .i_out_ready    (o_res.ready),
        .i_status       (w_status),
        .o_in_ready     (w_in_ready),
        .o_out_valid    (w_out_valid),
        .o_cmd          (w_cmd)
    );

    eed_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_sample    (i_smp.sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (w_result)
    );

endmodule

[bench/energy_endpoint_detector_tb.sv]
// ----------------------------------------------------------------------------
// energy_endpoint_detector_tb
// Drives command and sample transactions into the end-point detector, tracks
// the expected per-frame statistics in a scoreboard and checks each result
// transaction field by field, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module energy_endpoint_detector_tb;

    localparam int ITEMS = 1200;
    localparam int HOLD  = 40;

    class utterance_tracker;
        logic [eed_pkg::LEVEL_W-1:0]  silence_level;
        logic [eed_pkg::HANG_W-1:0]   hang_limit;
        logic [eed_pkg::FRAMES_W-1:0] frame_cap;
        int unsigned                  abs_sum;
        int unsigned                  sample_cnt;
        int unsigned                  silent_cnt;
        int unsigned                  frame_cnt;
        int unsigned                  min_seen;
        int unsigned                  max_seen;
        bit                           active;
        int                           mismatches;
        eed_pkg::t_result             expected_frames[$];

        function new();
            silence_level = eed_pkg::SILENCE_LEVEL_RST;
            hang_limit    = eed_pkg::HANG_LIMIT_RST;
            frame_cap     = eed_pkg::FRAME_CAP_RST;
            active        = 1'b0;
            mismatches    = 0;
            clear_utterance();
        endfunction

        function void clear_utterance();
            abs_sum    = 0;
            sample_cnt = 0;
            silent_cnt = 0;
            frame_cnt  = 0;
            min_seen   = 16'hFFFF;
            max_seen   = 0;
        endfunction

        function void write_register(logic [eed_pkg::IDX_W-1:0] idx,
                                     logic [eed_pkg::CFG_W-1:0] data);
            case (idx)
                eed_pkg::REG_SILENCE_LEVEL: silence_level = data[eed_pkg::LEVEL_W-1:0];
                eed_pkg::REG_HANG_LIMIT:    hang_limit    = data[eed_pkg::HANG_W-1:0];
                eed_pkg::REG_FRAME_CAP:     frame_cap     = data[eed_pkg::FRAMES_W-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the transaction is acted on, 0 when it is dropped.
        function bit note_transaction(bit cmd, logic [eed_pkg::SAMPLE_W-1:0] pcm, bit fe);
            int unsigned      energy;
            bit               silent;
            bit               done;
            eed_pkg::t_result r;
            if (cmd) begin
                clear_utterance();
                active = 1'b1;
                return 1'b1;
            end
            if (!active) return 1'b0;
            if (sample_cnt < eed_pkg::FRAME_SAMPLES) begin
                abs_sum += pcm[eed_pkg::SAMPLE_W-1] ? 32'h10000 - pcm : pcm;
                sample_cnt++;
            end
            if (!fe) return 1'b1;
            energy = (sample_cnt != 0) ? abs_sum / sample_cnt : 0;
            abs_sum    = 0;
            sample_cnt = 0;
            if (energy < min_seen) min_seen = energy;
            if (energy > max_seen) max_seen = energy;
            silent = energy < silence_level;
            if (silent) begin
                if (silent_cnt < eed_pkg::SILENT_MAX) silent_cnt++;
            end else begin
                silent_cnt = 0;
            end
            if (frame_cnt < eed_pkg::FRAMES_MAX) frame_cnt++;
            done = (silent_cnt >= hang_limit) || (frame_cnt >= frame_cap);
            if (done) active = 1'b0;
            r.frame_energy = energy[eed_pkg::ENERGY_W-1:0];
            r.frame_silent = silent;
            r.silent_run   = silent_cnt[eed_pkg::HANG_W-1:0];
            r.frame_total  = frame_cnt[eed_pkg::FRAMES_W-1:0];
            r.energy_min   = min_seen[eed_pkg::ENERGY_W-1:0];
            r.energy_max   = max_seen[eed_pkg::ENERGY_W-1:0];
            r.done_res     = done;
            expected_frames.push_back(r);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_frame(eed_pkg::t_result seen);
            eed_pkg::t_result want;
            if (expected_frames.size() == 0) begin
                $error("unexpected result: frame_energy %0d, frame_total %0d",
                       seen.frame_energy, seen.frame_total);
                mismatches++;
                return;
            end
            want = expected_frames.pop_front();
            compare_field("frame_energy", want.frame_energy, seen.frame_energy);
            compare_field("frame_silent", want.frame_silent, seen.frame_silent);
            compare_field("silent_run",   want.silent_run,   seen.silent_run);
            compare_field("frame_total",  want.frame_total,  seen.frame_total);
            compare_field("energy_min",   want.energy_min,   seen.energy_min);
            compare_field("energy_max",   want.energy_max,   seen.energy_max);
            compare_field("done_res",     want.done_res,     seen.done_res);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    eed_smp_if smp();
    eed_res_if res();
    eed_cfg_if cfg();

    energy_endpoint_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    utterance_tracker tracker = new();
    int               items_taken = 0;
    bit               src_bursts = 1'b1;
    bit               sink_bursts = 1'b1;
    int unsigned      sink_gap = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (sink_gap != 0) begin
            sink_gap  <= sink_gap - 1;
            res.ready <= (sink_gap == 1);
        end else if (sink_bursts && $urandom_range(0, 5) == 0) begin
            sink_gap  <= $urandom_range(1, 9);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        eed_pkg::t_result seen;
        if (i_rst_n && res.valid && res.ready) begin
            seen.frame_energy = res.frame_energy;
            seen.frame_silent = res.frame_silent;
            seen.silent_run   = res.silent_run;
            seen.frame_total  = res.frame_total;
            seen.energy_min   = res.energy_min;
            seen.energy_max   = res.energy_max;
            seen.done_res     = res.done_res;
            tracker.check_frame(seen);
        end
    end

    // Leaves valid high on return so back-to-back transactions need no toggle.
    task automatic send_item(bit cmd, logic [eed_pkg::SAMPLE_W-1:0] pcm, bit fe);
        if (src_bursts && $urandom_range(0, 4) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        smp.valid     <= 1'b1;
        smp.cmd       <= cmd;
        smp.sample    <= pcm;
        smp.frame_end <= fe;
        do @(posedge i_clk); while (!smp.ready);
        if (tracker.note_transaction(cmd, pcm, fe)) items_taken++;
    endtask

    task automatic settle();
        smp.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (HOLD) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [eed_pkg::IDX_W-1:0] idx,
                             logic [eed_pkg::CFG_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        tracker.write_register(idx, data);
    endtask

    task automatic configure(logic [eed_pkg::CFG_W-1:0] level,
                             logic [eed_pkg::CFG_W-1:0] hang,
                             logic [eed_pkg::CFG_W-1:0] cap);
        settle();
        write_reg(eed_pkg::REG_SILENCE_LEVEL, level);
        write_reg(eed_pkg::REG_HANG_LIMIT, hang);
        write_reg(eed_pkg::REG_FRAME_CAP, cap);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [eed_pkg::SAMPLE_W-1:0] pick_pcm(int style, int amp);
        int v;
        v = int'($urandom_range(0, 2 * amp)) - amp;
        if (style == 0) return v[eed_pkg::SAMPLE_W-1:0];
        if (style == 1) return eed_pkg::SAMPLE_W'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return eed_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_frame(int len, bit closed);
        int style;
        int amp;
        style = $urandom_range(0, 2);
        amp   = $urandom_range(0, 150);
        for (int i = 0; i < len; i++)
            send_item(1'b0, pick_pcm(style, amp), closed && (i == len - 1));
    endtask

    task automatic run_utterance();
        int frames;
        frames = $urandom_range(1, 40);
        send_item(1'b1, eed_pkg::SAMPLE_W'($urandom), 1'($urandom));
        for (int f = 0; f < frames && tracker.active; f++) begin
            if ($urandom_range(0, 29) == 0) begin
                send_frame($urandom_range(1, 3), 1'b0);
                send_item(1'b1, eed_pkg::SAMPLE_W'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 119) == 0)
                send_frame($urandom_range(150, 170), 1'b1);
            else
                send_frame($urandom_range(1, 6), 1'b1);
        end
        if (!tracker.active)
            repeat ($urandom_range(0, 2))
                send_item(1'b0, eed_pkg::SAMPLE_W'($urandom), 1'($urandom));
    endtask

    initial begin
        int phase;
        int phase_end;
        bit tail;
        i_rst_n       <= 1'b0;
        smp.valid     <= 1'b0;
        smp.cmd       <= 1'b0;
        smp.sample    <= '0;
        smp.frame_end <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.index     <= eed_pkg::REG_SILENCE_LEVEL;
        cfg.data      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset levels: dropped while idle, extremes, silence edge, restart
        send_item(1'b0, 16'd1234, 1'b1);
        send_item(1'b1, 16'h8000, 1'b1);
        send_item(1'b0, 16'h8000, 1'b1);
        send_item(1'b0, 16'h7FFF, 1'b0);
        send_item(1'b0, 16'hFFFF, 1'b1);
        send_item(1'b0, 16'd0, 1'b1);
        send_item(1'b0, 16'd59, 1'b1);
        send_item(1'b0, 16'd60, 1'b1);
        send_item(1'b0, -16'sd60, 1'b0);
        send_item(1'b0, 16'd61, 1'b0);
        send_item(1'b0, -16'sd58, 1'b1);
        send_item(1'b0, 16'd5, 1'b0);
        send_item(1'b1, 16'd9, 1'b0);
        send_item(1'b0, 16'd300, 1'b1);

        // hangover ends the utterance, then samples drop until the next start
        configure(16'd60, 16'd1, 16'd600);
        send_item(1'b1, 16'd0, 1'b0);
        send_item(1'b0, 16'd3, 1'b1);
        send_item(1'b0, 16'd999, 1'b1);
        send_item(1'b0, -16'sd7, 1'b0);

        configure(16'd60, 16'd50, 16'd0);
        send_item(1'b1, 16'd0, 1'b0);
        send_item(1'b0, 16'd1000, 1'b1);

        configure(16'd60, 16'd50, 16'd2);
        send_item(1'b1, 16'd0, 1'b0);
        send_item(1'b0, 16'd4000, 1'b1);
        send_item(1'b0, -16'sd4000, 1'b1);

        // frames past and at the sample limit
        configure(16'd60, 16'd50, 16'd600);
        send_item(1'b1, 16'd0, 1'b0);
        send_frame(165, 1'b1);
        send_frame(eed_pkg::FRAME_SAMPLES, 1'b1);

        phase = 0;
        while (items_taken < ITEMS) begin
            tail        = items_taken >= ITEMS * 4 / 5;
            src_bursts  = !tail && ($urandom_range(0, 2) != 0);
            sink_bursts = !tail && ($urandom_range(0, 2) != 0);
            case (phase % 6)
                0: configure(16'd0, 16'd0, 16'd0);
                1: configure(16'h8000, 16'd1023, 16'd4095);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: configure(16'($urandom_range(0, 150)), 16'hFC01, 16'hF003);
                default: configure(16'($urandom_range(0, 150)), 16'($urandom_range(1, 6)),
                                   16'($urandom_range(1, 25)));
            endcase
            phase_end = items_taken + 120;
            while (items_taken < phase_end && items_taken < ITEMS) run_utterance();
            phase++;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("energy_endpoint_detector: match");
        end else begin
            $display("energy_endpoint_detector: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("energy_endpoint_detector: mismatch");
        $finish;
    end
endmodule

[sim.f]
hdl/eed_pkg.sv
hdl/eed_smp_if.sv
hdl/eed_res_if.sv
hdl/eed_cfg_if.sv
hdl/eed_datapath.sv
hdl/eed_ctrl.sv
hdl/energy_endpoint_detector.sv
bench/energy_endpoint_detector_tb.sv
